[rtl/core/acl_first_match_packet_filter_defines.svh]
// ----------------------------------------------------------------------------
// ACL filter assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ACL_FIRST_MATCH_PACKET_FILTER_DEFINES_SVH
`define ACL_FIRST_MATCH_PACKET_FILTER_DEFINES_SVH
// implication under reset
`define ACL_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("acl assertion failed");
// next-cycle implication under reset
`define ACL_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("acl assertion failed");
`endif

[rtl/core/acl_pkg.sv]
// ----------------------------------------------------------------------------
// ACL package
// Types and constants of the first-match access-list filter.
// ----------------------------------------------------------------------------
package acl_pkg;
  localparam int RuleSlots   = 64;
  localparam int SlotBits    = $clog2(RuleSlots);
  localparam int CountBits   = 32;
  localparam logic [6:0] ReadDefault   = 7'd64;
  localparam logic [6:0] ReadPermitted = 7'd65;
  localparam logic [6:0] ReadDropped   = 7'd66;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [0:0] CfgEnabled = 1'b0;
  localparam logic [0:0] CfgRules   = 1'b1;

  typedef enum logic [2:0] {
    OP_HEAD = 3'd0, OP_SRC_PORT = 3'd1, OP_DST_PORT = 3'd2,
    OP_CLASSIFY = 3'd3, OP_READ = 3'd4, OP_NONE5 = 3'd5, OP_NONE6 = 3'd6,
    OP_NONE7 = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PM_EQ = 3'd0, PM_NEQ = 3'd1, PM_GT = 3'd2, PM_LT = 3'd3, PM_RANGE = 3'd4,
    PM_BAD5 = 3'd5, PM_BAD6 = 3'd6, PM_BAD7 = 3'd7
  } port_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN, ST_CHECK, ST_CNT_RD, ST_CNT_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [6:0]  rule_index;
    logic        permit_action;
    logic [7:0]  protocol;
    logic        any_protocol;
    logic [31:0] src_address;
    logic [31:0] src_mask;
    logic [31:0] dst_address;
    logic [31:0] dst_mask;
    logic [2:0]  port_mode;
    logic [15:0] port_first;
    logic [15:0] port_second;
  } in_item_t;

  typedef struct packed {
    logic        permit;
    logic        default_hit;
    logic [5:0]  hit_index;
    logic [31:0] counter_value;
  } out_item_t;

  typedef struct packed {
    logic        permit;
    logic        any_protocol;
    logic [7:0]  protocol;
    logic [31:0] src_address;
    logic [31:0] src_mask;
    logic [31:0] dst_address;
    logic [31:0] dst_mask;
  } rule_head_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] first;
    logic [15:0] second;
  } port_cond_t;

  function automatic logic port_ok(port_cond_t c, logic [15:0] p);
    logic r;
    unique case (port_mode_t'(c.mode))
      PM_EQ:    r = (p == c.first);
      PM_NEQ:   r = (p != c.first);
      PM_GT:    r = (p > c.first);
      PM_LT:    r = (p < c.first);
      PM_RANGE: r = (c.first <= p) && (p <= c.second);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

[rtl/core/acl_ram.sv]
// ----------------------------------------------------------------------------
// ACL generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module acl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/acl_first_match_packet_filter.sv]
// ----------------------------------------------------------------------------
// ACL first-match packet filter
// Rules are scanned in slot order up to the configured count (at most 64) and the
// first match wins; rules are read one per cycle through the shared read address
// of the three rule RAMs, and the hit counter is then read and updated.
// One item in flight: the next is taken only once out_valid has dropped.
// Reset: a clearing pass zeroes all 64 hit counters; no items accepted meanwhile.
// ----------------------------------------------------------------------------
module acl_first_match_packet_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  acl_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output acl_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [6:0]        cfg_data
);
  import acl_pkg::*;

  state_t state, state_next;
  in_item_t cur;
  logic filter_enabled;
  logic [6:0] rules_in_use;
  logic [SlotBits:0] scan, limit;
  logic found;
  logic [SlotBits-1:0] hit_slot;
  logic [CountBits-1:0] default_hit_count, permitted_total, dropped_total;
  logic out_full;
  logic take;
  logic permit_q;
  out_item_t cnt_res;

  logic head_we, sp_we, dp_we, cnt_we;
  logic [SlotBits-1:0] rd_addr, cnt_waddr, cnt_raddr;
  rule_head_t head_wd, head_rd;
  port_cond_t cond_wd, sp_rd, dp_rd;
  logic [CountBits-1:0] cnt_wd, cnt_rd;

  acl_ram #(.Width($bits(rule_head_t)), .Depth(RuleSlots)) u_head (
    .clk, .we(head_we), .waddr(cur.rule_index[SlotBits-1:0]), .wdata(head_wd),
    .raddr(rd_addr), .rdata(head_rd));
  acl_ram #(.Width($bits(port_cond_t)), .Depth(RuleSlots)) u_sp (
    .clk, .we(sp_we), .waddr(cur.rule_index[SlotBits-1:0]), .wdata(cond_wd),
    .raddr(rd_addr), .rdata(sp_rd));
  acl_ram #(.Width($bits(port_cond_t)), .Depth(RuleSlots)) u_dp (
    .clk, .we(dp_we), .waddr(cur.rule_index[SlotBits-1:0]), .wdata(cond_wd),
    .raddr(rd_addr), .rdata(dp_rd));
  acl_ram #(.Width(CountBits), .Depth(RuleSlots)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wd),
    .raddr(cnt_raddr), .rdata(cnt_rd));

  logic slot_ok;
  assign slot_ok = (cur.rule_index < 7'(RuleSlots));
  assign in_stall = (state != ST_IDLE) || out_full;
  assign take = in_valid && !in_stall;
  assign out_valid = out_full;
  assign limit = (rules_in_use > 7'(RuleSlots)) ? (SlotBits+1)'(RuleSlots)
                                                 : rules_in_use[SlotBits:0];
  assign rd_addr = scan[SlotBits-1:0];

  // match of rule read in the previous cycle
  logic prev_valid, match;
  logic [SlotBits-1:0] prev_slot;
  always_comb begin
    logic ports;
    ports = !head_rd.any_protocol &&
            (head_rd.protocol == ProtoTcp || head_rd.protocol == ProtoUdp);
    match = (head_rd.any_protocol || head_rd.protocol == cur.protocol) &&
            ((cur.src_address & head_rd.src_mask) == head_rd.src_address) &&
            ((cur.dst_address & head_rd.dst_mask) == head_rd.dst_address) &&
            (!ports || (port_ok(sp_rd, cur.port_first) &&
                        port_ok(dp_rd, cur.port_second)));
  end

  assign head_wd = '{permit: cur.permit_action, any_protocol: cur.any_protocol,
                     protocol: cur.protocol,
                     src_address: cur.src_address & cur.src_mask,
                     src_mask: cur.src_mask,
                     dst_address: cur.dst_address & cur.dst_mask,
                     dst_mask: cur.dst_mask};
  assign cond_wd = '{mode: cur.port_mode, first: cur.port_first,
                     second: cur.port_second};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (take) begin
        if (in_data.operation == OP_CLASSIFY && filter_enabled) begin
          state_next = ST_SCAN;
        end else if (in_data.operation == OP_READ) begin
          state_next = ST_CNT_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR:  if (scan == (SlotBits+1)'(RuleSlots - 1)) state_next = ST_IDLE;
      ST_SCAN:   if ((prev_valid && match) || scan >= limit) state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_CNT_RD;
      ST_CNT_RD: state_next = ST_CNT_WR;
      ST_CNT_WR: state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  logic is_cls;
  assign is_cls = (cur.operation == OP_CLASSIFY);
  always_comb begin
    head_we = 1'b0;
    sp_we = 1'b0;
    dp_we = 1'b0;
    cnt_we = 1'b0;
    cnt_waddr = hit_slot;
    cnt_wd = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
    cnt_raddr = is_cls ? hit_slot : cur.rule_index[SlotBits-1:0];
    unique case (state)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        cnt_waddr = scan[SlotBits-1:0];
        cnt_wd = '0;
      end
      ST_DONE: begin
        head_we = (cur.operation == OP_HEAD) && slot_ok;
        sp_we = (cur.operation == OP_SRC_PORT) && slot_ok;
        dp_we = (cur.operation == OP_DST_PORT) && slot_ok;
      end
      ST_CNT_WR: cnt_we = is_cls && found;
      default: ;
    endcase
  end

  // result of a classify or a counter read
  always_comb begin
    cnt_res = '0;
    if (is_cls) begin
      cnt_res.permit = found && permit_q;
      cnt_res.default_hit = !found;
      cnt_res.hit_index = found ? 6'(hit_slot) : 6'd0;
    end else begin
      priority if (cur.rule_index == ReadDefault)
        cnt_res.counter_value = default_hit_count;
      else if (cur.rule_index == ReadPermitted)
        cnt_res.counter_value = permitted_total;
      else if (cur.rule_index == ReadDropped)
        cnt_res.counter_value = dropped_total;
      else if (slot_ok)
        cnt_res.counter_value = cnt_rd;
      else
        cnt_res.counter_value = '0;
    end
  end

  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      scan <= '0;
      out_full <= 1'b0;
      filter_enabled <= 1'b0;
      rules_in_use <= '0;
      default_hit_count <= '0;
      permitted_total <= '0;
      dropped_total <= '0;
      prev_valid <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgEnabled: filter_enabled <= cfg_data[0];
          CfgRules:   rules_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (out_full && !out_stall) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          scan <= '0;
          prev_valid <= 1'b0;
          found <= 1'b0;
          if (take) cur <= in_data;
        end
        ST_CLEAR: scan <= scan + 1'b1;
        ST_SCAN: begin
          if (prev_valid && match) begin
            found <= 1'b1;
            hit_slot <= prev_slot;
          end else if (scan < limit) begin
            prev_valid <= 1'b1;
            prev_slot <= scan[SlotBits-1:0];
            scan <= scan + 1'b1;
          end
        end
        ST_CHECK: ;
        ST_CNT_RD: ;
        ST_CNT_WR: begin
          out_data <= cnt_res;
          if (is_cls) begin
            if (!found) default_hit_count <= sat_inc(default_hit_count);
            if (found && permit_q) permitted_total <= sat_inc(permitted_total);
            else dropped_total <= sat_inc(dropped_total);
          end
        end
        ST_DONE: begin
          out_full <= 1'b1;
          if (cur.operation != OP_CLASSIFY && cur.operation != OP_READ) begin
            out_data <= '0;
          end else if (is_cls && !filter_enabled) begin
            out_data <= '{permit: 1'b1, default: '0};
          end
        end
        default: ;
      endcase
    end
  end

  // permit bit of the hit rule, captured while its head is on the read port
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && prev_valid && match) permit_q <= head_rd.permit;
  end
endmodule

[rtl/core/acl_check.sv]
// ----------------------------------------------------------------------------
// ACL port checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "acl_first_match_packet_filter_defines.svh"
module acl_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input acl_pkg::out_item_t out_data
);
  import acl_pkg::*;
  `ACL_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ACL_ASSERT_IMP(a_no_take_full, clk, rst, out_valid, in_stall)
  `ACL_ASSERT_IMP(a_dflt_deny, clk, rst, out_valid && out_data.default_hit, !out_data.permit)
  `ACL_ASSERT_IMP(a_dflt_idx, clk, rst, out_valid && out_data.default_hit, out_data.hit_index == 6'd0)
endmodule

bind acl_first_match_packet_filter acl_check u_acl_check (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data);

[tb/sv/acl_first_match_packet_filter_test.sv]
// ----------------------------------------------------------------------------
// ACL first-match packet filter testbench
// Drives rule writes, classify items and counter reads through the valid/stall
// input channel, predicts each result from a local copy of the rule table and
// counters, and compares every result in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module acl_first_match_packet_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import acl_pkg::*;

  class acl_scoreboard;
    rule_head_t heads[RuleSlots];
    port_cond_t src_cond[RuleSlots];
    port_cond_t dst_cond[RuleSlots];
    logic [31:0] hits[RuleSlots];
    logic [31:0] dflt_cnt, perm_cnt, drop_cnt;
    logic enabled;
    logic [6:0] rules_used;
    out_item_t pending[$];
    int errors;
    int classified;
    int reads;

    function new();
      for (int i = 0; i < RuleSlots; i++) hits[i] = '0;
      dflt_cnt = '0; perm_cnt = '0; drop_cnt = '0;
      enabled = 1'b0; rules_used = '0; errors = 0; classified = 0; reads = 0;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] c);
      return (c == '1) ? c : c + 1;
    endfunction

    function logic cond_ok(port_cond_t c, logic [15:0] p);
      case (port_mode_t'(c.mode))
        PM_EQ:    return p == c.first;
        PM_NEQ:   return p != c.first;
        PM_GT:    return p > c.first;
        PM_LT:    return p < c.first;
        PM_RANGE: return (c.first <= p) && (p <= c.second);
        default:  return 1'b0;
      endcase
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int n;
      int found;
      logic ports;
      rule_head_t h;
      r = '0;
      found = -1;
      case (op_t'(it.operation))
        OP_HEAD: if (it.rule_index < RuleSlots) begin
          heads[it.rule_index] = '{it.permit_action, it.any_protocol, it.protocol,
            it.src_address & it.src_mask, it.src_mask,
            it.dst_address & it.dst_mask, it.dst_mask};
        end
        OP_SRC_PORT: if (it.rule_index < RuleSlots)
          src_cond[it.rule_index] = '{it.port_mode, it.port_first, it.port_second};
        OP_DST_PORT: if (it.rule_index < RuleSlots)
          dst_cond[it.rule_index] = '{it.port_mode, it.port_first, it.port_second};
        OP_CLASSIFY: begin
          classified++;
          if (!enabled) begin
            r.permit = 1'b1;
          end else begin
            n = (rules_used > RuleSlots) ? RuleSlots : rules_used;
            for (int i = 0; i < n && found < 0; i++) begin
              h = heads[i];
              ports = !h.any_protocol && (h.protocol == ProtoTcp || h.protocol == ProtoUdp);
              if (!h.any_protocol && h.protocol != it.protocol) continue;
              if ((it.src_address & h.src_mask) != h.src_address) continue;
              if (ports && !cond_ok(src_cond[i], it.port_first)) continue;
              if ((it.dst_address & h.dst_mask) != h.dst_address) continue;
              if (ports && !cond_ok(dst_cond[i], it.port_second)) continue;
              found = i;
            end
            if (found >= 0) begin
              hits[found] = sat_inc(hits[found]);
              r.permit = heads[found].permit;
              r.hit_index = found[5:0];
            end else begin
              dflt_cnt = sat_inc(dflt_cnt);
              r.default_hit = 1'b1;
            end
            if (r.permit) perm_cnt = sat_inc(perm_cnt);
            else drop_cnt = sat_inc(drop_cnt);
          end
        end
        OP_READ: begin
          reads++;
          if (it.rule_index == ReadDefault) r.counter_value = dflt_cnt;
          else if (it.rule_index == ReadPermitted) r.counter_value = perm_cnt;
          else if (it.rule_index == ReadDropped) r.counter_value = drop_cnt;
          else if (it.rule_index < RuleSlots) r.counter_value = hits[it.rule_index];
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.permit !== want.permit) begin
        $display("%0t: permit expected %0d actual %0d", $realtime, want.permit, got.permit);
        errors++;
      end
      if (got.default_hit !== want.default_hit) begin
        $display("%0t: default_hit expected %0d actual %0d", $realtime,
                 want.default_hit, got.default_hit);
        errors++;
      end
      if (got.hit_index !== want.hit_index) begin
        $display("%0t: hit_index expected %0d actual %0d", $realtime,
                 want.hit_index, got.hit_index);
        errors++;
      end
      if (got.counter_value !== want.counter_value) begin
        $display("%0t: counter_value expected %0h actual %0h", $realtime,
                 want.counter_value, got.counter_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  acl_scoreboard sb = new();
  int cycle_count = 0;
  bit hold_off = 1'b0;
  bit bursty = 1'b1;
  int burst_left = 0;

  localparam int CycleLimit = 400000;

  acl_first_match_packet_filter u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!bursty) out_stall <= 1'b0;
    else if (($urandom_range(0, 15) < 3)) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [6:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgEnabled) sb.enabled = val[0];
    else sb.rules_used = val;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_rule(int slot, bit narrow);
    in_item_t it;
    it = rand_item();
    it.operation = OP_HEAD;
    it.rule_index = 7'(slot);
    case ($urandom_range(0, 3))
      0: it.protocol = ProtoTcp;
      1: it.protocol = ProtoUdp;
      2: it.protocol = 8'($urandom_range(0, 3));
      default: ;
    endcase
    it.any_protocol = ($urandom_range(0, 3) == 0);
    if (narrow) begin
      it.src_mask = 32'hff000000 << $urandom_range(0, 24);
      it.dst_mask = $urandom_range(0, 1) ? 32'h0 : 32'hffff0000;
      it.src_address[31:28] = 4'ha;
      it.dst_address[31:28] = 4'hc;
    end
    send_item(it);
    it = rand_item();
    it.operation = OP_SRC_PORT;
    it.rule_index = 7'(slot);
    it.port_mode = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    it.port_first = rand_port();
    it.port_second = rand_port();
    send_item(it);
    it.operation = OP_DST_PORT;
    it.port_mode = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    it.port_first = rand_port();
    it.port_second = rand_port();
    send_item(it);
  endtask

  task automatic classify(bit targeted);
    in_item_t it;
    it = rand_item();
    it.operation = OP_CLASSIFY;
    if (targeted) begin
      it.src_address[31:28] = 4'ha;
      it.dst_address[31:28] = 4'hc;
      case ($urandom_range(0, 3))
        0: it.protocol = ProtoTcp;
        1: it.protocol = ProtoUdp;
        2: it.protocol = 8'($urandom_range(0, 3));
        default: ;
      endcase
      it.port_first = rand_port();
      it.port_second = rand_port();
    end
    send_item(it);
  endtask

  task automatic read_counter(logic [6:0] idx);
    in_item_t it;
    it = rand_item();
    it.operation = OP_READ;
    it.rule_index = idx;
    send_item(it);
  endtask

  initial begin
    in_item_t it;
    int pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: disabled filter, rule writes, extremes and odd operations
    classify(1'b0);
    for (int s = 0; s < RuleSlots; s++) write_rule(s, 1'b1);
    it = '1;
    it.operation = OP_HEAD;
    it.rule_index = 7'd64;
    send_item(it);
    it.operation = OP_NONE5; send_item(it);
    it.operation = OP_NONE6; send_item(it);
    it.operation = OP_NONE7; send_item(it);
    it = '0;
    it.operation = OP_SRC_PORT;
    it.rule_index = 7'd0;
    it.port_mode = PM_RANGE;
    it.port_first = 16'd100;
    it.port_second = 16'd10;
    send_item(it);
    read_counter(7'd127);
    write_cfg(CfgEnabled, 1'b1);
    write_cfg(CfgRules, 7'd0);
    classify(1'b1);
    write_cfg(CfgRules, 7'd127);
    it = '1;
    it.operation = OP_CLASSIFY;
    send_item(it);
    classify(1'b1);
    read_counter(ReadDefault);
    read_counter(ReadPermitted);
    read_counter(ReadDropped);
    read_counter(7'd0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 12; k++) classify(1'b1);
    join

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_cfg(CfgRules, 7'd64);
        1: write_cfg(CfgRules, 7'($urandom_range(1, 8)));
        2: write_cfg(CfgRules, 7'd1);
        default: write_cfg(CfgEnabled, 1'b0);
      endcase
      bursty = (ph != 1);
      for (int k = 0; k < 48; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) classify(pick < 10);
        else if (pick < 14) write_rule($urandom_range(0, RuleSlots - 1), pick == 12);
        else if (pick < 17) read_counter(7'($urandom_range(0, 68)));
        else if (pick < 18) read_counter(7'($urandom_range(64, 66)));
        else send_item(rand_item());
      end
    end
    bursty = 1'b1;
    drain();
    $display("Covered %0d classify items and %0d counter reads over 64-rule tables,",
             sb.classified, sb.reads);
    $display("with the filter on and off and several rule counts under random stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
